// ===== sv/lru_handle_tag_cache_macros.svh =====
// assertion macros for the lru handle tag cache
`ifndef LRU_HANDLE_TAG_CACHE_MACROS_SVH
`define LRU_HANDLE_TAG_CACHE_MACROS_SVH

// same-cycle implication, checked out of reset
`define LHTC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lhtc assertion failed");

// next-cycle implication, checked out of reset
`define LHTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lhtc assertion failed");

`endif

// ===== sv/lhtc_pkg.sv =====
// shared types and constants for the lru handle tag cache
`timescale 1ns / 1ps

package lhtc_pkg;

    localparam int TAG_W   = 32;
    localparam int STAMP_W = 64;
    localparam int SLOT_W  = 3;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_ACCESS    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INVAL_ONE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INVAL_ALL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic finish;
    } lhtc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } lhtc_sts_t;

endpackage

// ===== sv/lru_handle_tag_cache.sv =====
// top level of the lru handle tag cache
`timescale 1ns / 1ps

// fully associative tag table with timestamp lru replacement
// input channel: in_valid/in_ready carries one request (action, file_num, open_ok)
//   action access looks the tag up, fills a victim on a miss when open_ok is set
//   action invalidate-one clears a matching entry, invalidate-all clears every entry
// output channel: out_valid/out_ready carries exactly one result per request
// each access or invalidate-one scans the entries one per cycle through the
//   tag/stamp memory read port (accept, NUM_ENTRIES reads, a drain for the
//   last read data, commit); a miss with no free entry evicts even without open_ok
// invalidate-all and the unused code go straight from accept to commit
// the result appears in the output register the cycle after commit
// a request can be accepted while the previous result still waits in the output register;
//   its commit waits until that register is free, so a stalled receiver holds the block
// reset empties every entry and clears the access counter; no clearing pass is needed
module lru_handle_tag_cache
    import lhtc_pkg::*;
#(
    parameter int NUM_ENTRIES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ACT_W-1:0]  action,
    input  logic [TAG_W-1:0]  file_num,
    input  logic              open_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic [SLOT_W-1:0] slot,
    output logic              stored,
    output logic              evicted,
    output logic [TAG_W-1:0]  evicted_index
);

    lhtc_cmd_t cmd;
    lhtc_sts_t sts;

    // sequencer: accept, scan, commit
    lhtc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    // entry storage, lru trackers and the result register
    lhtc_dpath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .file_num      (file_num),
        .open_ok       (open_ok),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .slot          (slot),
        .stored        (stored),
        .evicted       (evicted),
        .evicted_index (evicted_index)
    );

endmodule

// ===== sv/lhtc_ctrl.sv =====
// controller state machine for the lru handle tag cache
`timescale 1ns / 1ps

module lhtc_ctrl
    import lhtc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ACT_W-1:0] action,
    input  lhtc_sts_t        sts,
    output lhtc_cmd_t        cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (action == ACT_ACCESS || action == ACT_INVAL_ONE)
                        state_next = S_SCAN;
                    else
                        state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.rd = 1'b1;
                if (sts.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/lhtc_dpath.sv =====
// datapath for the lru handle tag cache: tag and stamp memories, scan trackers, result register
`timescale 1ns / 1ps

`include "lru_handle_tag_cache_macros.svh"

module lhtc_dpath
    import lhtc_pkg::*;
#(
    parameter int NUM_ENTRIES = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lhtc_cmd_t        cmd,
    output lhtc_sts_t        sts,
    input  logic [ACT_W-1:0] action,
    input  logic [TAG_W-1:0] file_num,
    input  logic             open_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             hit,
    output logic [SLOT_W-1:0] slot,
    output logic             stored,
    output logic             evicted,
    output logic [TAG_W-1:0] evicted_index
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    // memories, no reset
    logic [TAG_W-1:0]   tag_mem   [NUM_ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [NUM_ENTRIES];
    logic [TAG_W-1:0]   rd_tag_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;

    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [STAMP_W-1:0]     counter_reg, counter_next;

    // held item
    logic [ACT_W-1:0] item_action_reg;
    logic [TAG_W-1:0] item_tag_reg;
    logic             item_open_reg;

    // scan control
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             pend_reg;

    // scan trackers
    logic               match_found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic               inv_found_reg;
    logic [IDX_W-1:0]   inv_idx_reg;
    logic               best_set_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [TAG_W-1:0]   best_tag_reg;

    // result register
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_stored_reg;
    logic              out_evicted_reg;
    logic [TAG_W-1:0]  out_ev_idx_reg;

    // commit logic
    logic               res_hit, res_stored, res_evicted;
    logic [IDX_W-1:0]   res_slot;
    logic [TAG_W-1:0]   res_ev_idx;
    logic               tag_we, stamp_we;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   victim_idx;
    logic [STAMP_W-1:0] counter_inc;
    logic               entry_v;

    assign sts.scan_last = (addr_reg == LAST_IDX);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign victim_idx  = inv_found_reg ? inv_idx_reg : best_idx_reg;
    assign counter_inc = counter_reg + {{(STAMP_W-1){1'b0}}, 1'b1};
    assign entry_v     = valid_reg[idx_reg];

    always_comb
    begin
        res_hit      = 1'b0;
        res_slot     = '0;
        res_stored   = 1'b0;
        res_evicted  = 1'b0;
        res_ev_idx   = '0;
        valid_next   = valid_reg;
        counter_next = counter_reg;
        tag_we       = 1'b0;
        stamp_we     = 1'b0;
        wr_idx       = victim_idx;
        if (cmd.finish)
        begin
            unique case (item_action_reg)
                ACT_ACCESS:
                begin
                    if (match_found_reg)
                    begin
                        wr_idx       = match_idx_reg;
                        counter_next = counter_inc;
                        stamp_we     = 1'b1;
                        res_hit      = 1'b1;
                        res_slot     = match_idx_reg;
                        res_stored   = 1'b1;
                    end
                    else
                    begin
                        // all slots valid: evict the oldest stamp
                        if (!inv_found_reg)
                        begin
                            res_evicted        = 1'b1;
                            res_ev_idx         = best_tag_reg;
                            res_slot           = victim_idx;
                            valid_next[wr_idx] = 1'b0;
                        end
                        if (item_open_reg)
                        begin
                            counter_next       = counter_inc;
                            valid_next[wr_idx] = 1'b1;
                            tag_we             = 1'b1;
                            stamp_we           = 1'b1;
                            res_stored         = 1'b1;
                            res_slot           = victim_idx;
                        end
                    end
                end
                ACT_INVAL_ONE:
                begin
                    if (match_found_reg)
                    begin
                        wr_idx             = match_idx_reg;
                        valid_next[wr_idx] = 1'b0;
                        res_hit            = 1'b1;
                        res_slot           = match_idx_reg;
                    end
                end
                ACT_INVAL_ALL:
                begin
                    valid_next = '0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[wr_idx] <= item_tag_reg;
        if (stamp_we)
            stamp_mem[wr_idx] <= counter_inc;
        if (cmd.rd)
        begin
            rd_tag_reg   <= tag_mem[addr_reg];
            rd_stamp_reg <= stamp_mem[addr_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_action_reg <= action;
            item_tag_reg    <= file_num;
            item_open_reg   <= open_ok;
        end
        if (cmd.rd)
            idx_reg <= addr_reg;
        if (pend_reg && entry_v && rd_tag_reg == item_tag_reg && !match_found_reg)
            match_idx_reg <= idx_reg;
        if (pend_reg && !entry_v && !inv_found_reg)
            inv_idx_reg <= idx_reg;
        if (pend_reg && entry_v && (!best_set_reg || rd_stamp_reg < best_stamp_reg))
        begin
            best_idx_reg   <= idx_reg;
            best_stamp_reg <= rd_stamp_reg;
            best_tag_reg   <= rd_tag_reg;
        end
        if (cmd.finish)
        begin
            out_hit_reg     <= res_hit;
            out_slot_reg    <= SLOT_W'(res_slot);
            out_stored_reg  <= res_stored;
            out_evicted_reg <= res_evicted;
            out_ev_idx_reg  <= res_ev_idx;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            counter_reg     <= '0;
            addr_reg        <= '0;
            pend_reg        <= 1'b0;
            match_found_reg <= 1'b0;
            inv_found_reg   <= 1'b0;
            best_set_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            counter_reg <= counter_next;
            pend_reg    <= cmd.rd;
            if (cmd.load)
            begin
                addr_reg        <= '0;
                match_found_reg <= 1'b0;
                inv_found_reg   <= 1'b0;
                best_set_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.rd)
                    addr_reg <= addr_reg + {{(IDX_W-1){1'b0}}, 1'b1};
                if (pend_reg && entry_v && rd_tag_reg == item_tag_reg)
                    match_found_reg <= 1'b1;
                if (pend_reg && !entry_v)
                    inv_found_reg <= 1'b1;
                if (pend_reg && entry_v)
                    best_set_reg <= 1'b1;
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign slot          = out_slot_reg;
    assign stored        = out_stored_reg;
    assign evicted       = out_evicted_reg;
    assign evicted_index = out_ev_idx_reg;

    `LHTC_ASSERT_IMPL(a_hit_no_evict, out_valid_reg && out_hit_reg, !out_evicted_reg)
    `LHTC_ASSERT_NEXT(a_store_sets_valid, cmd.finish && res_stored, valid_reg[$past(wr_idx)])
    `LHTC_ASSERT_NEXT(a_counter_on_commit, !cmd.finish, $stable(counter_reg))
    `LHTC_ASSERT_IMPL(a_finish_out_free, cmd.finish, !out_valid_reg || out_ready)

endmodule
